// File: sv/emfu_pkg.sv
// shared types, register codes and constants for the excitable-medium frame update unit
// no dependencies; every other file but emfu_line_ram refers to this package by scoped names
package emfu_pkg;

    // configuration port
    localparam int CFG_DW  = 11;
    localparam int CFG_IW  = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_DECAY  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    // register reset values
    localparam logic [8:0]        DECAY_RST  = 9'd230;
    localparam logic [8:0]        DECAY_ONE  = 9'd256;
    localparam logic [CFG_DW-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_DW-1:0] HEIGHT_RST = 11'd768;

    // default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // request kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [7:0] PIX_FULL = 8'hFF;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_in;
        logic       seed;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } pix_out_t;

    // one column of the 3x3 window
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } col_t;

    // which pixels of a window column may count as neighbours
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } win_mask_t;

    // position flags of the centre pixel travelling with an advance
    typedef struct packed {
        logic emit;
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } ctl_t;

    typedef struct packed {
        logic       adv;
        logic [7:0] pix;
        ctl_t       ctl;
    } issue_t;

    // (255*d*d)>>16 with d at most one in Q1.8
    function automatic logic [7:0] thr_of(input logic [8:0] d);
        logic [17:0] dd;
        logic [25:0] p;
        dd = 18'(d) * 18'(d);
        p  = {dd, 8'b0} - 26'(dd);
        return p[23:16];
    endfunction

endpackage

// File: sv/emfu_line_ram.sv
// one line store: single-port memory, read before write, registered read data
// depends on nothing else
module emfu_line_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] ram_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        rdata_reg <= ram_reg[addr];
        if (we) begin
            ram_reg[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/emfu_win_cell.sv
// one column cell of the 3x3 window: holds a column, passes it on, ORs in its neighbour hits
// uses emfu_pkg types
module emfu_win_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  emfu_pkg::col_t    col_in,
    input  emfu_pkg::win_mask_t mask,
    input  logic              hit_in,
    output emfu_pkg::col_t    col_out,
    output logic              hit_out
);

    emfu_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;
    assign hit_out = hit_in
                   || (mask.top && col_reg.top == emfu_pkg::PIX_FULL)
                   || (mask.mid && col_reg.mid == emfu_pkg::PIX_FULL)
                   || (mask.bot && col_reg.bot == emfu_pkg::PIX_FULL);

endmodule

// File: sv/emfu_seq.sv
// request sequencer: frame geometry, input and output positions, window advances
// uses emfu_pkg types and codes
module emfu_seq #(
    parameter int MAX_WIDTH  = emfu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = emfu_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  emfu_pkg::pix_in_t             s_data,
    input  logic                          space_ok,
    input  logic [emfu_pkg::CFG_DW-1:0]   cfg_width,
    input  logic [emfu_pkg::CFG_DW-1:0]   cfg_height,
    output logic                          s_ready,
    output emfu_pkg::issue_t              iss,
    output logic [$clog2(MAX_WIDTH)-1:0]  iss_addr
);

    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(MAX_WIDTH + 2);

    logic [DW-1:0] act_w_reg, act_w_next;
    logic [HW-1:0] act_h_reg, act_h_next;
    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [LW-1:0] lead_reg, lead_next;
    logic          extra_reg, extra_next;

    logic [DW-1:0] w_cfg, w_eff;
    logic [HW-1:0] h_cfg, h_eff;
    logic          idle, accept, is_pix, in_done, col_wrap;
    logic          pix_take, emit_pix, flush_emit, emit, adv;
    logic          out_cwrap, out_rlast, last;

    // geometry clamped to 1..MAX
    always_comb begin
        if (cfg_width == '0) begin
            w_cfg = DW'(1);
        end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
            w_cfg = DW'(MAX_WIDTH);
        end else begin
            w_cfg = DW'(cfg_width);
        end
        if (cfg_height == '0) begin
            h_cfg = HW'(1);
        end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
            h_cfg = HW'(MAX_HEIGHT);
        end else begin
            h_cfg = HW'(cfg_height);
        end
    end

    // frame start: geometry is latched by the first pixel
    assign idle  = (col_reg == '0) && (in_row_reg == '0);
    assign w_eff = idle ? w_cfg : act_w_reg;
    assign h_eff = idle ? h_cfg : act_h_reg;

    assign s_ready    = space_ok && !extra_reg;
    assign accept     = s_valid && s_ready;
    assign is_pix     = s_data.func == emfu_pkg::FUNC_PIXEL;
    assign in_done    = in_row_reg == h_eff;
    assign col_wrap   = DW'(col_reg) == w_eff - DW'(1);
    assign pix_take   = accept && is_pix && !in_done;
    assign emit_pix   = pix_take && (lead_reg == LW'(w_eff) + LW'(1));
    assign flush_emit = accept && (s_data.func == emfu_pkg::FUNC_FLUSH) && in_done;
    assign emit       = emit_pix || flush_emit;
    // a single-row frame needs one more advance than it has flush requests
    assign adv        = pix_take || flush_emit || extra_reg;
    assign out_cwrap  = DW'(out_col_reg) == w_eff - DW'(1);
    assign out_rlast  = HW'(out_row_reg) == h_eff - HW'(1);
    assign last       = emit && out_cwrap && out_rlast;

    always_comb begin
        act_w_next   = act_w_reg;
        act_h_next   = act_h_reg;
        col_next     = col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        extra_next   = 1'b0;
        if (accept && is_pix && idle) begin
            act_w_next = w_cfg;
            act_h_next = h_cfg;
        end
        if (adv) begin
            col_next = col_wrap ? '0 : col_reg + CW'(1);
        end
        if (pix_take && col_wrap) begin
            in_row_next = in_row_reg + HW'(1);
            extra_next  = h_eff == HW'(1);
        end
        if (emit) begin
            out_col_next = out_cwrap ? '0 : out_col_reg + CW'(1);
            if (out_cwrap) begin
                out_row_next = out_row_reg + RW'(1);
            end
        end
        if (pix_take && !emit_pix) begin
            lead_next = lead_reg + LW'(1);
        end else if (flush_emit) begin
            lead_next = lead_reg - LW'(1);
        end
        if (last) begin
            col_next     = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
            extra_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_w_reg   <= DW'(MAX_WIDTH) < DW'(emfu_pkg::WIDTH_RST)
                           ? DW'(MAX_WIDTH) : DW'(emfu_pkg::WIDTH_RST);
            act_h_reg   <= HW'(MAX_HEIGHT) < HW'(emfu_pkg::HEIGHT_RST)
                           ? HW'(MAX_HEIGHT) : HW'(emfu_pkg::HEIGHT_RST);
            col_reg     <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
            extra_reg   <= 1'b0;
        end else begin
            act_w_reg   <= act_w_next;
            act_h_reg   <= act_h_next;
            col_reg     <= col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
            extra_reg   <= extra_next;
        end
    end

    always_comb begin
        iss.adv       = adv;
        iss.pix       = extra_reg ? '0
                      : (s_data.seed ? emfu_pkg::PIX_FULL : s_data.pixel_in);
        iss.ctl.emit  = emit;
        iss.ctl.top   = out_row_reg == '0;
        iss.ctl.bot   = out_rlast;
        iss.ctl.left  = out_col_reg == '0;
        iss.ctl.right = out_cwrap;
        iss.ctl.last  = last;
    end

    assign iss_addr = col_reg;

endmodule

// File: sv/excitable_medium_frame_update_unit.sv
// pipeline: a result passes the stage registers and the output queue before it is offered; results trail the
// pixel stream by frame_width+1 pixels, drained by flush requests after the frame
// throughput: one request per cycle while the output queue has a free slot, set by the line store ports and
// window shift; s_ready also drops once per frame when the frame is a single row
// reset: synchronous; clears positions, queue and registers to defaults; line stores not cleared
module excitable_medium_frame_update_unit #(
    parameter int MAX_WIDTH  = emfu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = emfu_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  emfu_pkg::pix_in_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output emfu_pkg::pix_out_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [emfu_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [emfu_pkg::CFG_DW-1:0]   cfg_wr_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration
    logic [8:0]                  decay_reg;
    logic [7:0]                  thr_reg;
    logic [emfu_pkg::CFG_DW-1:0] width_reg;
    logic [emfu_pkg::CFG_DW-1:0] height_reg;
    logic [8:0]                  decay_wr;

    assign decay_wr = (cfg_wr_data[8:0] > emfu_pkg::DECAY_ONE)
                      ? emfu_pkg::DECAY_ONE : cfg_wr_data[8:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg  <= emfu_pkg::DECAY_RST;
            thr_reg    <= emfu_pkg::thr_of(emfu_pkg::DECAY_RST);
            width_reg  <= emfu_pkg::WIDTH_RST;
            height_reg <= emfu_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                emfu_pkg::REG_DECAY: begin
                    decay_reg <= decay_wr;
                    thr_reg   <= emfu_pkg::thr_of(decay_wr);
                end
                emfu_pkg::REG_WIDTH: begin
                    width_reg <= cfg_wr_data;
                end
                emfu_pkg::REG_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    emfu_pkg::issue_t iss;
    logic [CW-1:0]    iss_addr;
    logic [emfu_pkg::FIFO_CW-1:0] credit_reg;
    logic             pop;

    emfu_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .space_ok   (credit_reg != '0),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .s_ready    (s_ready),
        .iss        (iss),
        .iss_addr   (iss_addr)
    );

    // stage 1: first line store read and written, second line store written in the cycle after
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]     pix1_reg, pix2_reg, mid2_reg;
    logic [CW-1:0]  addr1_reg;
    emfu_pkg::ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic [7:0]     q1, q2;

    emfu_line_ram #(.DEPTH(MAX_WIDTH)) u_line0 (
        .aclk  (aclk),
        .we    (iss.adv),
        .addr  (iss_addr),
        .wdata (iss.pix),
        .rdata (q1)
    );

    emfu_line_ram #(.DEPTH(MAX_WIDTH)) u_line1 (
        .aclk  (aclk),
        .we    (v1_reg),
        .addr  (addr1_reg),
        .wdata (q1),
        .rdata (q2)
    );

    // window: cell 0 is the newest column, cell 1 holds the centre
    emfu_pkg::col_t      col_new, c0_col, c1_col;
    emfu_pkg::win_mask_t m0, m1, m2;
    logic                h0, h1, h2;

    assign col_new.top = q2;
    assign col_new.mid = mid2_reg;
    assign col_new.bot = pix2_reg;

    assign m0.top = !ctl3_reg.top && !ctl3_reg.right;
    assign m0.mid = !ctl3_reg.right;
    assign m0.bot = !ctl3_reg.bot && !ctl3_reg.right;
    assign m1.top = !ctl3_reg.top;
    assign m1.mid = 1'b0;
    assign m1.bot = !ctl3_reg.bot;
    assign m2.top = !ctl3_reg.top && !ctl3_reg.left;
    assign m2.mid = !ctl3_reg.left;
    assign m2.bot = !ctl3_reg.bot && !ctl3_reg.left;

    emfu_win_cell u_cell0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (v2_reg),
        .col_in   (col_new),
        .mask     (m0),
        .hit_in   (h1),
        .col_out  (c0_col),
        .hit_out  (h0)
    );

    emfu_win_cell u_cell1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (v2_reg),
        .col_in   (c0_col),
        .mask     (m1),
        .hit_in   (h2),
        .col_out  (c1_col),
        .hit_out  (h1)
    );

    emfu_win_cell u_cell2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (v2_reg),
        .col_in   (c1_col),
        .mask     (m2),
        .hit_in   (1'b0),
        .col_out  (),
        .hit_out  (h2)
    );

    // decay of the centre pixel
    logic [16:0] dec_prod;
    logic [7:0]  dec4_reg;
    logic        hit4_reg, last4_reg;
    emfu_pkg::pix_out_t result;

    assign dec_prod = 17'(c1_col.mid) * 17'(decay_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= iss.adv;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && ctl2_reg.emit;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        pix1_reg  <= iss.pix;
        addr1_reg <= iss_addr;
        ctl1_reg  <= iss.ctl;
        pix2_reg  <= pix1_reg;
        mid2_reg  <= q1;
        ctl2_reg  <= ctl1_reg;
        ctl3_reg  <= ctl2_reg;
        dec4_reg  <= dec_prod[15:8];
        hit4_reg  <= h0;
        last4_reg <= ctl3_reg.last;
    end

    assign result.pixel_out  = (hit4_reg && dec4_reg < thr_reg) ? emfu_pkg::PIX_FULL : dec4_reg;
    assign result.frame_last = last4_reg;

    // output queue; a slot is reserved when the releasing request is taken
    emfu_pkg::pix_out_t            fifo_reg [emfu_pkg::FIFO_DEPTH];
    logic [emfu_pkg::FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [emfu_pkg::FIFO_CW-1:0]  count_reg;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != '0;
    assign m_data  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (v4_reg) begin
            fifo_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= emfu_pkg::FIFO_CW'(emfu_pkg::FIFO_DEPTH);
        end else begin
            if (v4_reg) begin
                wr_ptr_reg <= wr_ptr_reg + emfu_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + emfu_pkg::FIFO_AW'(1);
            end
            count_reg  <= count_reg + emfu_pkg::FIFO_CW'(v4_reg) - emfu_pkg::FIFO_CW'(pop);
            credit_reg <= credit_reg - emfu_pkg::FIFO_CW'(iss.ctl.emit && iss.adv)
                          + emfu_pkg::FIFO_CW'(pop);
        end
    end

endmodule

// File: sv/emfu_checker.sv
// port-level checks for excitable_medium_frame_update_unit, attached by bind
// uses emfu_pkg types and codes
module emfu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input emfu_pkg::pix_in_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input emfu_pkg::pix_out_t  m_data
);

    logic [31:0] pend_reg;
    logic [31:0] flush_reg;
    logic        in_acc, out_acc, flush_acc, last_acc;

    assign in_acc    = s_valid && s_ready;
    assign out_acc   = m_valid && m_ready;
    assign flush_acc = in_acc && s_data.func == emfu_pkg::FUNC_FLUSH;
    assign last_acc  = out_acc && m_data.frame_last;

    // requests taken minus results delivered; flushes taken minus frame ends delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            flush_reg <= '0;
        end else begin
            pend_reg  <= pend_reg + 32'(in_acc) - 32'(out_acc);
            flush_reg <= flush_reg + 32'(flush_acc) - 32'(last_acc);
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> pend_reg != '0)
        else $error("result delivered with no request behind it");

    a_last_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        last_acc |-> flush_reg != '0)
        else $error("frame end delivered before its flush request");

endmodule

bind excitable_medium_frame_update_unit emfu_checker u_emfu_checker (.*);
